[design/fta_pkg.sv]
package fta_pkg;

    // widths of the arithmetic path
    localparam int GainW  = 24;
    localparam int MomW   = 24;
    localparam int RatioW = 16;
    localparam int AngW   = 22;

    // register map
    typedef enum logic [2:0] {
        REG_GAIN_SINGLE_TILT = 3'd0,
        REG_GAIN_SINGLE_YAW  = 3'd1,
        REG_GAIN_DOUBLE_TILT = 3'd2,
        REG_GAIN_DOUBLE_YAW  = 3'd3,
        REG_DERIV_RATIO      = 3'd4
    } t_reg_idx;

    localparam logic [GainW-1:0]  RST_GAIN_SINGLE_TILT = 24'd429497;
    localparam logic [GainW-1:0]  RST_GAIN_SINGLE_YAW  = 24'd42950;
    localparam logic [GainW-1:0]  RST_GAIN_DOUBLE_TILT = 24'd429497;
    localparam logic [GainW-1:0]  RST_GAIN_DOUBLE_YAW  = 24'd4295;
    localparam logic [RatioW-1:0] RST_DERIV_RATIO      = 16'd1280;

    // clamp limits, 2^-24 rad
    localparam logic signed [AngW-1:0] LIM_TILT_HI     = 22'sd872415;
    localparam logic signed [AngW-1:0] LIM_TILT_LO     = -22'sd872415;
    localparam logic signed [AngW-1:0] LIM_YAW_HI      = 22'sd1459618;
    localparam logic signed [AngW-1:0] LIM_YAW_LO_LEFT = -22'sd1459618;
    localparam logic signed [AngW-1:0] LIM_YAW_LO_RGT  = -22'sd984823;

    // per-lane stage strobes and item flags
    typedef struct packed {
        logic ld_err;
        logic ld_prod;
        logic ld_corr;
        logic ld_deriv;
        logic update;
        logic foot;
    } t_lane_ctl;

endpackage

[design/fta_lane.sv]
module fta_lane
    import fta_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic [GainW-1:0]         i_gain,
    input  logic signed [MomW-1:0]   i_ref,
    input  logic signed [MomW-1:0]   i_meas,
    input  logic [RatioW-1:0]        i_ratio,
    input  logic signed [AngW-1:0]   i_lo,
    input  logic signed [AngW-1:0]   i_hi,
    output logic signed [AngW-1:0]   o_y
);

    logic signed [24:0] r_err;
    logic [GainW-1:0]   r_gain;
    logic signed [48:0] r_prod;
    logic signed [33:0] r_c;
    logic signed [34:0] r_diff;
    logic signed [50:0] r_d;
    logic signed [33:0] r_now  [2];
    logic signed [33:0] r_prev [2];

    logic signed [49:0] prod_full;
    logic signed [49:0] prod_rnd;
    logic signed [33:0] corr_new;
    logic signed [33:0] c_sel;
    logic signed [34:0] diff;
    logic signed [51:0] d_full;
    logic signed [51:0] d_rnd;
    logic signed [44:0] y_sum;
    logic signed [44:0] lo_x;
    logic signed [44:0] hi_x;

    assign prod_full = $signed({1'b0, r_gain}) * r_err;
    // round half up from 2^-40 to 2^-24 rad
    assign prod_rnd  = {r_prod[48], r_prod} + 50'sd32768;
    assign corr_new  = prod_rnd[49:16];
    assign c_sel     = i_ctl.update ? corr_new : r_now[i_ctl.foot];
    assign diff      = {c_sel[33], c_sel} - {r_prev[i_ctl.foot][33], r_prev[i_ctl.foot]};
    assign d_full    = $signed({1'b0, i_ratio}) * r_diff;
    // derivative term rounded half up from q8.8
    assign d_rnd     = {r_d[50], r_d} + 52'sd128;
    assign y_sum     = {{11{r_c[33]}}, r_c} + {d_rnd[51], d_rnd[51:8]};
    assign lo_x      = {{23{i_lo[AngW-1]}}, i_lo};
    assign hi_x      = {{23{i_hi[AngW-1]}}, i_hi};

    always_comb begin
        if (y_sum < lo_x) begin
            o_y = i_lo;
        end else if (y_sum > hi_x) begin
            o_y = i_hi;
        end else begin
            o_y = y_sum[AngW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_err) begin
            r_err  <= {i_ref[MomW-1], i_ref} - {i_meas[MomW-1], i_meas};
            r_gain <= i_gain;
        end
        if (i_ctl.ld_prod) begin
            r_prod <= prod_full[48:0];
        end
        if (i_ctl.ld_corr) begin
            r_c    <= c_sel;
            r_diff <= diff;
        end
        if (i_ctl.ld_deriv) begin
            r_d <= d_full[50:0];
        end
    end

    // per-foot correction history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now[0]  <= '0;
            r_now[1]  <= '0;
            r_prev[0] <= '0;
            r_prev[1] <= '0;
        end else if (i_ctl.ld_corr) begin
            r_now[i_ctl.foot]  <= c_sel;
            r_prev[i_ctl.foot] <= c_sel;
        end
    end

endmodule

[design/fta_merge.sv]
module fta_merge
    import fta_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_ld,
    input  logic signed [AngW-1:0] i_roll,
    input  logic signed [AngW-1:0] i_pitch,
    input  logic signed [AngW-1:0] i_yaw,
    output logic                   o_free,
    input  logic                   m_axis_tready,
    output logic                   m_axis_tvalid,
    output logic [63:0]            m_axis_tdata
);

    logic        r_valid;
    logic [63:0] r_data;

    assign o_free        = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ld && o_free) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld && o_free) begin
            r_data <= {i_yaw, i_pitch[AngW-2:0], i_roll[AngW-2:0]};
        end
    end

endmodule

[design/foot_torque_admittance.sv]
// the lanes hold one item at a time through error, multiply, correction, derivative and
// clamp stages into the output register, and accept no new beat until the item leaves
// the derivative stage; a full output register holds it there
// reset (i_rst_n low, synchronous): gains and deriv ratio to defaults, all stored
// corrections zero, pipeline and output register empty
module foot_torque_admittance
    import fta_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // support_side[0], tick_count[16:1], step_start_tick[32:17],
    // double_support_ticks[48:33], moment_ref_roll[72:49], moment_ref_pitch[96:73],
    // moment_ref_yaw[120:97], moment_meas_roll[144:121], moment_meas_pitch[168:145],
    // moment_meas_yaw[192:169], zero pad [199:193]
    input  logic [199:0] s_axis_tdata,
    // foot_select[0]
    input  logic [0:0]   s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // angle_roll[20:0], angle_pitch[41:21], angle_yaw[63:42]
    output logic [63:0]  m_axis_tdata,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // configuration registers
    logic [GainW-1:0]  r_gst;
    logic [GainW-1:0]  r_gsy;
    logic [GainW-1:0]  r_gdt;
    logic [GainW-1:0]  r_gdy;
    logic [RatioW-1:0] r_ratio;

    // stage occupancy: error, product, correction, derivative
    logic [3:0] r_stg;
    logic       r_update;
    logic       r_foot;

    logic             accept;
    logic             w_out_free;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;
    logic             foot_in;
    logic             side_in;
    logic [15:0]      tick_in;
    logic [15:0]      start_in;
    logic [15:0]      dst_in;
    logic signed [17:0] phase;
    logic             dbl;
    logic [GainW-1:0] gain_tilt;
    logic [GainW-1:0] gain_yaw;
    t_lane_ctl        ctl;
    logic signed [AngW-1:0] yaw_lo;
    logic signed [AngW-1:0] y_roll;
    logic signed [AngW-1:0] y_pitch;
    logic signed [AngW-1:0] y_yaw;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gst   <= RST_GAIN_SINGLE_TILT;
            r_gsy   <= RST_GAIN_SINGLE_YAW;
            r_gdt   <= RST_GAIN_DOUBLE_TILT;
            r_gdy   <= RST_GAIN_DOUBLE_YAW;
            r_ratio <= RST_DERIV_RATIO;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GAIN_SINGLE_TILT: r_gst   <= pwdata[GainW-1:0];
                REG_GAIN_SINGLE_YAW:  r_gsy   <= pwdata[GainW-1:0];
                REG_GAIN_DOUBLE_TILT: r_gdt   <= pwdata[GainW-1:0];
                REG_GAIN_DOUBLE_YAW:  r_gdy   <= pwdata[GainW-1:0];
                REG_DERIV_RATIO:      r_ratio <= pwdata[RatioW-1:0];
                default: ;  // unmapped addresses ignore writes
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GAIN_SINGLE_TILT: prdata = {8'd0, r_gst};
            REG_GAIN_SINGLE_YAW:  prdata = {8'd0, r_gsy};
            REG_GAIN_DOUBLE_TILT: prdata = {8'd0, r_gdt};
            REG_GAIN_DOUBLE_YAW:  prdata = {8'd0, r_gdy};
            REG_DERIV_RATIO:      prdata = {16'd0, r_ratio};
            default:              prdata = 32'd0;
        endcase
    end

    // unpack the input beat
    assign foot_in  = s_axis_tuser[0];
    assign side_in  = s_axis_tdata[0];
    assign tick_in  = s_axis_tdata[16:1];
    assign start_in = s_axis_tdata[32:17];
    assign dst_in   = s_axis_tdata[48:33];

    // one item in flight; a finished result may still sit in the output register
    assign s_axis_tready = (r_stg == 4'b0000);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // double support while the step phase is short of the window, negative phase too
    assign phase = $signed({2'b00, tick_in}) + 18'sd1 - $signed({2'b00, start_in});
    assign dbl   = phase < $signed({2'b00, dst_in});

    assign gain_tilt = dbl ? r_gdt : r_gst;
    assign gain_yaw  = dbl ? r_gdy : r_gsy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= 4'b0000;
        end else begin
            r_stg[0] <= accept;
            r_stg[1] <= r_stg[0];
            r_stg[2] <= r_stg[1];
            // last stage waits for the output register
            r_stg[3] <= r_stg[2] || (r_stg[3] && !w_out_free);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            // swing foot in single support keeps its stored correction
            r_update <= dbl || (side_in == foot_in);
            r_foot   <= foot_in;
        end
    end

    assign ctl.ld_err   = accept;
    assign ctl.ld_prod  = r_stg[0];
    assign ctl.ld_corr  = r_stg[1];
    assign ctl.ld_deriv = r_stg[2];
    assign ctl.update   = r_update;
    assign ctl.foot     = r_foot;

    // right yaw limit is asymmetric
    assign yaw_lo = r_foot ? LIM_YAW_LO_RGT : LIM_YAW_LO_LEFT;

    fta_lane u_lane_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_gain  (gain_tilt),
        .i_ref   (s_axis_tdata[72:49]),
        .i_meas  (s_axis_tdata[144:121]),
        .i_ratio (r_ratio),
        .i_lo    (LIM_TILT_LO),
        .i_hi    (LIM_TILT_HI),
        .o_y     (y_roll)
    );

    fta_lane u_lane_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_gain  (gain_tilt),
        .i_ref   (s_axis_tdata[96:73]),
        .i_meas  (s_axis_tdata[168:145]),
        .i_ratio (r_ratio),
        .i_lo    (LIM_TILT_LO),
        .i_hi    (LIM_TILT_HI),
        .o_y     (y_pitch)
    );

    fta_lane u_lane_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_gain  (gain_yaw),
        .i_ref   (s_axis_tdata[120:97]),
        .i_meas  (s_axis_tdata[192:169]),
        .i_ratio (r_ratio),
        .i_lo    (yaw_lo),
        .i_hi    (LIM_YAW_HI),
        .o_y     (y_yaw)
    );

    // lane results meet in the output register
    fta_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ld          (r_stg[3]),
        .i_roll        (y_roll),
        .i_pitch       (y_pitch),
        .i_yaw         (y_yaw),
        .o_free        (w_out_free),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_stg == 4'b0001)
        else $error("accepted beat did not enter the first stage alone");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_stg))
        else $error("more than one item in the lanes");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_stg[3]))
        else $error("result beat without a finished item");

    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg[3] && !w_out_free |=> r_stg[3])
        else $error("finished item dropped while output was full");
`endif

endmodule
